// ===== sv/gai_pkg.sv =====
// Shared types and constants of the gyro angle integrator.
package gai_pkg;

    typedef logic signed [15:0] rate_t;
    typedef logic signed [7:0]  offset_t;
    typedef logic        [7:0]  dt_t;
    typedef logic        [22:0] angle_t;
    typedef logic        [8:0]  deg_t;

    // Register map of the configuration port
    typedef enum logic [1:0] {
        REG_OFFSET_X     = 2'd0,
        REG_OFFSET_Y     = 2'd1,
        REG_OFFSET_Z     = 2'd2,
        REG_SENSOR_READY = 2'd3
    } cfg_index_t;

    localparam offset_t OFFSET_X_RESET = 8'sd5;
    localparam offset_t OFFSET_Y_RESET = -8'sd6;
    localparam offset_t OFFSET_Z_RESET = 8'sd41;

    // One full turn in units of 1/14375 degree
    localparam int     UNITS_PER_DEG = 14375;
    localparam angle_t FULL_TURN     = 23'd5175000;
    localparam int     RATE_DEADBAND = 8;
    localparam dt_t    ELAPSED_MAX   = 8'd150;

    // floor(angle / 14375) = (angle * DEG_RECIP) >> DEG_SHIFT for angle < 2^23
    localparam int          DEG_SHIFT = 37;
    localparam logic [23:0] DEG_RECIP = 24'd9560971;

endpackage

// ===== sv/gai_axis.sv =====
// One axis of the angle update: offset, deadband, rate times interval, wrap.
module gai_axis (
    input  gai_pkg::rate_t   rate,
    input  gai_pkg::offset_t offset,
    input  gai_pkg::dt_t     dt,
    input  logic             enable,
    input  gai_pkg::angle_t  angle,
    output gai_pkg::angle_t  angle_new
);
    import gai_pkg::*;

    logic signed [16:0] corrected;
    logic signed [8:0]  dt_s;
    logic signed [25:0] step;
    logic signed [25:0] sum;
    logic signed [25:0] wrapped;
    logic               moving;

    always_comb
    begin
        corrected = 17'(rate) + 17'(offset);
        dt_s      = $signed({1'b0, dt});
        step      = 26'(corrected) * 26'(dt_s);
        sum       = $signed({3'b000, angle}) + step;
        moving    = (corrected >= 17'sd8) || (corrected <= -17'sd8);
        if (sum >= $signed({3'b000, FULL_TURN}))
        begin
            wrapped = sum - $signed({3'b000, FULL_TURN});
        end
        else if (sum < 26'sd0)
        begin
            wrapped = sum + $signed({3'b000, FULL_TURN});
        end
        else
        begin
            wrapped = sum;
        end
        angle_new = (enable && moving) ? wrapped[22:0] : angle;
    end

endmodule

// ===== sv/gai_deg.sv =====
// Whole-degree conversion of a fine angle by reciprocal multiplication.
module gai_deg (
    input  gai_pkg::angle_t angle,
    output gai_pkg::deg_t   deg
);
    import gai_pkg::*;

    logic [46:0] prod;

    always_comb
    begin
        prod = {24'd0, angle} * {23'd0, DEG_RECIP};
        deg  = prod[DEG_SHIFT +: 9];
    end

endmodule

// ===== sv/gyro_angle_integrator_top.sv =====
// Top level of the gyro angle integrator.
//
// Input channel (in_valid / in_ready) carries one three-axis rate sample and
// the milliseconds since the previous sample. Output channel
// (out_valid / out_ready) returns yaw, pitch and roll in whole degrees,
// one result item for every input item, in order.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the three
// calibration offsets and the sensor_ready enable; write it while idle.
// An accepted item passes the input register, then the angle registers (one
// multiply-add-wrap per axis), and then the output register, which takes the
// degree conversion (one multiply per axis). Throughput is one item per cycle
// while the receiver takes every result.
// Each stage holds its item only while the stage after it is full, so a
// stalled receiver still lets up to two more items be taken in before
// in_ready drops.
// Reset clears the angles to zero, loads the default offsets and turns
// sensor_ready off, so samples leave the angles unchanged until enabled.
module gyro_angle_integrator_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gai_pkg::rate_t   rate_x,
    input  gai_pkg::rate_t   rate_y,
    input  gai_pkg::rate_t   rate_z,
    input  gai_pkg::dt_t     elapsed_ms,
    output logic             out_valid,
    input  logic             out_ready,
    output gai_pkg::deg_t    yaw_deg,
    output gai_pkg::deg_t    pitch_deg,
    output gai_pkg::deg_t    roll_deg,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data
);
    import gai_pkg::*;

    // Configuration
    offset_t offset_x_reg, offset_x_next;
    offset_t offset_y_reg, offset_y_next;
    offset_t offset_z_reg, offset_z_next;
    logic    sensor_ready_reg, sensor_ready_next;

    // Input stage
    logic  in_valid_reg, in_valid_next;
    rate_t rate_x_reg, rate_y_reg, rate_z_reg;
    dt_t   dt_reg;

    // Angle stage: the angle registers hold the result of the item in this stage
    logic   ang_valid_reg, ang_valid_next;
    angle_t yaw_fine_reg, yaw_fine_next;
    angle_t pitch_fine_reg, pitch_fine_next;
    angle_t roll_fine_reg, roll_fine_next;

    // Output stage
    logic out_valid_reg, out_valid_next;
    deg_t yaw_deg_reg, pitch_deg_reg, roll_deg_reg;
    deg_t yaw_deg_next, pitch_deg_next, roll_deg_next;

    logic out_free, ang_free, in_free;
    logic in_take, ang_take, out_take;
    cfg_index_t cfg_sel;

    gai_axis u_axis_yaw (
        .rate      (rate_x_reg),
        .offset    (offset_x_reg),
        .dt        (dt_reg),
        .enable    (sensor_ready_reg),
        .angle     (yaw_fine_reg),
        .angle_new (yaw_fine_next)
    );

    gai_axis u_axis_pitch (
        .rate      (rate_y_reg),
        .offset    (offset_y_reg),
        .dt        (dt_reg),
        .enable    (sensor_ready_reg),
        .angle     (pitch_fine_reg),
        .angle_new (pitch_fine_next)
    );

    gai_axis u_axis_roll (
        .rate      (rate_z_reg),
        .offset    (offset_z_reg),
        .dt        (dt_reg),
        .enable    (sensor_ready_reg),
        .angle     (roll_fine_reg),
        .angle_new (roll_fine_next)
    );

    gai_deg u_deg_yaw   (.angle(yaw_fine_reg),   .deg(yaw_deg_next));
    gai_deg u_deg_pitch (.angle(pitch_fine_reg), .deg(pitch_deg_next));
    gai_deg u_deg_roll  (.angle(roll_fine_reg),  .deg(roll_deg_next));

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        ang_free = !ang_valid_reg || out_free;
        in_free  = !in_valid_reg || ang_free;

        in_take  = in_valid && in_free;
        ang_take = in_valid_reg && ang_free;
        out_take = ang_valid_reg && out_free;

        in_valid_next  = in_take || (in_valid_reg && !ang_free);
        ang_valid_next = ang_take || (ang_valid_reg && !out_free);
        out_valid_next = out_take || (out_valid_reg && !out_ready);

        cfg_sel           = cfg_index_t'(cfg_index);
        offset_x_next     = offset_x_reg;
        offset_y_next     = offset_y_reg;
        offset_z_next     = offset_z_reg;
        sensor_ready_next = sensor_ready_reg;
        if (cfg_we)
        begin
            case (cfg_sel)
                REG_OFFSET_X:     offset_x_next     = offset_t'(cfg_data);
                REG_OFFSET_Y:     offset_y_next     = offset_t'(cfg_data);
                REG_OFFSET_Z:     offset_z_next     = offset_t'(cfg_data);
                REG_SENSOR_READY: sensor_ready_next = cfg_data[0];
                default:          sensor_ready_next = sensor_ready_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg     <= OFFSET_X_RESET;
            offset_y_reg     <= OFFSET_Y_RESET;
            offset_z_reg     <= OFFSET_Z_RESET;
            sensor_ready_reg <= 1'b0;
            in_valid_reg     <= 1'b0;
            ang_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            yaw_fine_reg     <= '0;
            pitch_fine_reg   <= '0;
            roll_fine_reg    <= '0;
        end
        else
        begin
            offset_x_reg     <= offset_x_next;
            offset_y_reg     <= offset_y_next;
            offset_z_reg     <= offset_z_next;
            sensor_ready_reg <= sensor_ready_next;
            in_valid_reg     <= in_valid_next;
            ang_valid_reg    <= ang_valid_next;
            out_valid_reg    <= out_valid_next;
            // Advance the angles exactly once per item, as it enters the angle stage
            if (ang_take)
            begin
                yaw_fine_reg   <= yaw_fine_next;
                pitch_fine_reg <= pitch_fine_next;
                roll_fine_reg  <= roll_fine_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rate_x_reg <= rate_x;
            rate_y_reg <= rate_y;
            rate_z_reg <= rate_z;
            // Clamp long intervals so one wrap always suffices
            dt_reg     <= (elapsed_ms > ELAPSED_MAX) ? ELAPSED_MAX : elapsed_ms;
        end
        if (out_take)
        begin
            yaw_deg_reg   <= yaw_deg_next;
            pitch_deg_reg <= pitch_deg_next;
            roll_deg_reg  <= roll_deg_next;
        end
    end

    assign in_ready  = in_free;
    assign out_valid = out_valid_reg;
    assign yaw_deg   = yaw_deg_reg;
    assign pitch_deg = pitch_deg_reg;
    assign roll_deg  = roll_deg_reg;

endmodule

// ===== sv/gai_checker.sv =====
// Port-level checks of the gyro angle integrator and their binding.
module gai_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input gai_pkg::deg_t yaw_deg,
    input gai_pkg::deg_t pitch_deg,
    input gai_pkg::deg_t roll_deg
);
    import gai_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(yaw_deg) && $stable(pitch_deg) && $stable(roll_deg))
        else $error("stalled result changed");

    // Angles stay within one turn
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (yaw_deg < 9'd360) && (pitch_deg < 9'd360) && (roll_deg < 9'd360))
        else $error("degree out of range");

    // out_valid is high once an accepted item has had time to pass the pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##3 out_valid)
        else $error("result late");

    // An empty output register never blocks the input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule

bind gyro_angle_integrator_top gai_checker u_gai_checker (.*);
